// File: rtl/ftbd_pkg.sv
`default_nettype none

package ftbd_pkg;

  // Crossing levels around the 128 midpoint.
  localparam logic [7:0] RISE_LEVEL = 8'd138;
  localparam logic [7:0] FALL_LEVEL = 8'd118;
  localparam logic [7:0] SAMPLE_MID = 8'd128;

  // Configuration register indexes.
  localparam logic [1:0] REG_LONG_HALF   = 2'd0;
  localparam logic [1:0] REG_SYNC_VALUE  = 2'd1;
  localparam logic [1:0] REG_CARRIER_RUN = 2'd2;

  // Configuration reset values.
  localparam logic [7:0] LONG_HALF_RST   = 8'd12;
  localparam logic [7:0] SYNC_VALUE_RST  = 8'h2A;
  localparam logic [4:0] CARRIER_RUN_RST = 5'd16;

  // Framer slots: idle, eight data slots, then the stop slot.
  localparam logic [3:0] FR_IDLE = 4'd0;
  localparam logic [3:0] FR_STOP = 4'd9;

  // Byte event reported with each bit.
  typedef enum logic [1:0] {
    FS_NONE      = 2'd0,
    FS_GOOD      = 2'd1,
    FS_BAD_START = 2'd2,
    FS_BAD_STOP  = 2'd3
  } frame_status_e;

  // Settings used by the framer and carrier detector.
  typedef struct packed {
    logic [7:0] sync_value;
    logic [4:0] carrier_run;
  } back_cfg_t;

  // Bit queue status.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// File: rtl/ftbd_front.sv
`default_nettype none

module ftbd_front
  import ftbd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] sample_i,
  input  wire logic [7:0] long_half_i,
  output logic            bit_push_o,
  output logic            bit_value_o
);

  typedef enum logic [2:0] {
    PH_SEEK      = 3'd0,
    PH_COUNT     = 3'd1,
    PH_ZERO_RISE = 3'd2,
    PH_ONE_FALL  = 3'd3,
    PH_ONE_RISE  = 3'd4
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] prev_q;
  logic       have_prev_q;
  logic [7:0] count_q, count_d;
  logic [7:0] count_inc;
  logic       rise, fall;

  // Crossing detection against the previous sample.
  assign rise = have_prev_q && (prev_q <= RISE_LEVEL) && (sample_i > RISE_LEVEL);
  assign fall = have_prev_q && (prev_q >= FALL_LEVEL) && (sample_i < FALL_LEVEL);

  // The half-cycle count saturates at its top value.
  assign count_inc = (count_q == 8'hFF) ? count_q : count_q + 8'd1;

  // Half-cycle classification and bit completion.
  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    bit_push_o  = 1'b0;
    bit_value_o = 1'b0;
    unique case (phase_q)
      PH_COUNT: begin
        count_d = count_inc;
        if (fall) begin
          phase_d = (count_inc > long_half_i) ? PH_ZERO_RISE : PH_ONE_FALL;
        end
      end
      PH_ZERO_RISE: begin
        if (rise) begin
          bit_push_o  = accept_i;
          bit_value_o = 1'b0;
          phase_d     = PH_COUNT;
          count_d     = 8'd0;
        end
      end
      PH_ONE_FALL: begin
        if (fall) begin
          phase_d = PH_ONE_RISE;
        end
      end
      PH_ONE_RISE: begin
        if (rise) begin
          bit_push_o  = accept_i;
          bit_value_o = 1'b1;
          phase_d     = PH_COUNT;
          count_d     = 8'd0;
        end
      end
      default: begin
        phase_d = PH_SEEK;
        if (rise) begin
          phase_d = PH_COUNT;
          count_d = 8'd0;
        end
      end
    endcase
  end

  // State advances only on an accepted sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SEEK;
      prev_q      <= SAMPLE_MID;
      have_prev_q <= 1'b0;
      count_q     <= 8'd0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      prev_q      <= sample_i;
      have_prev_q <= 1'b1;
      count_q     <= count_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ftbd_queue.sv
`default_nettype none

module ftbd_queue
  import ftbd_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire logic push_bit_i,
  input  wire logic pop_i,
  output logic      pop_bit_o,
  output q_stat_t   stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Depth-1:0] mem_q;
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign stat_o.full  = (count_q == CntW'(Depth));
  assign stat_o.empty = (count_q == '0);
  assign pop_bit_o    = mem_q[rd_ptr_q];

  // Bit storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_bit_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/ftbd_back.sv
`default_nettype none

module ftbd_back
  import ftbd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire back_cfg_t  cfg_i,
  input  wire logic       q_empty_i,
  input  wire logic       q_bit_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            bit_value_o,
  output frame_status_e   frame_status_o,
  output logic [7:0]      byte_value_o,
  output logic            carrier_found_o,
  output logic            sync_match_o
);

  logic [3:0]    pos_q, pos_d;
  logic [7:0]    shift_q, shift_d;
  logic [4:0]    run_q, run_d;
  frame_status_e status_d;
  logic [7:0]    byte_d;
  logic          sync_d;
  logic          out_valid_q;

  // Take a bit whenever the result register is free or being emptied.
  assign q_pop_o     = !q_empty_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;

  // Framer and carrier run for the bit at the head of the queue.
  always_comb begin
    pos_d    = pos_q;
    shift_d  = shift_q;
    status_d = FS_NONE;
    byte_d   = 8'd0;
    sync_d   = 1'b0;
    if (pos_q == FR_IDLE) begin
      if (!q_bit_i) begin
        pos_d   = 4'd1;
        shift_d = 8'd0;
      end else begin
        status_d = FS_BAD_START;
      end
    end else if (pos_q < FR_STOP) begin
      // Data arrives LSB first, so shift in from the top.
      shift_d = {q_bit_i, shift_q[7:1]};
      pos_d   = pos_q + 4'd1;
    end else begin
      if (q_bit_i) begin
        status_d = FS_GOOD;
        byte_d   = shift_q;
        sync_d   = (shift_q == cfg_i.sync_value);
      end else begin
        status_d = FS_BAD_STOP;
      end
      pos_d = FR_IDLE;
    end

    // A run at or past a lowered limit is clamped to it.
    if (q_bit_i) begin
      run_d = (run_q >= cfg_i.carrier_run) ? cfg_i.carrier_run : run_q + 5'd1;
    end else begin
      run_d = 5'd0;
    end
  end

  // Framer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= FR_IDLE;
      shift_q     <= 8'd0;
      run_q       <= 5'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        pos_q   <= pos_d;
        shift_q <= shift_d;
        run_q   <= run_d;
      end
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      bit_value_o     <= q_bit_i;
      frame_status_o  <= status_d;
      byte_value_o    <= byte_d;
      carrier_found_o <= (run_d >= cfg_i.carrier_run);
      sync_match_o    <= sync_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/fsk_tape_bit_byte_decoder_unit.sv
// Path: a bit completed by an accepted sample is written into the bit queue at the edge
// that accepts it, then popped into the result register and shown on out_valid_o.
// Throughput: one sample per cycle while the bit queue has room; at most one result
// per sample.
// Reset: rst_ni clears all control state and restores the configuration registers to
// their defaults at once; there is no clearing pass.
`default_nettype none

module fsk_tape_bit_byte_decoder_unit
  import ftbd_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       sample_valid_i,
  output logic            sample_stall_o,
  input  wire logic [7:0] sample_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            bit_value_o,
  output logic [1:0]      frame_status_o,
  output logic [7:0]      byte_value_o,
  output logic            carrier_found_o,
  output logic            sync_match_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);

  logic          sample_accept;
  logic [7:0]    long_half_q;
  back_cfg_t     back_cfg_q;
  logic          push, push_bit, pop, pop_bit;
  q_stat_t       q_stat;
  frame_status_e status;

  // Samples are taken whenever the bit queue has room.
  assign sample_stall_o = q_stat.full;
  assign sample_accept  = sample_valid_i && !sample_stall_o;
  assign cfg_ready_o    = 1'b1;
  assign frame_status_o = status;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_half_q            <= LONG_HALF_RST;
      back_cfg_q.sync_value  <= SYNC_VALUE_RST;
      back_cfg_q.carrier_run <= CARRIER_RUN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_LONG_HALF:   long_half_q            <= cfg_data_i;
        REG_SYNC_VALUE:  back_cfg_q.sync_value  <= cfg_data_i;
        REG_CARRIER_RUN: back_cfg_q.carrier_run <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  ftbd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (sample_accept),
    .sample_i    (sample_i),
    .long_half_i (long_half_q),
    .bit_push_o  (push),
    .bit_value_o (push_bit)
  );

  ftbd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_bit_i (push_bit),
    .pop_i      (pop),
    .pop_bit_o  (pop_bit),
    .stat_o     (q_stat)
  );

  ftbd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (back_cfg_q),
    .q_empty_i       (q_stat.empty),
    .q_bit_i         (pop_bit),
    .q_pop_o         (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .bit_value_o     (bit_value_o),
    .frame_status_o  (status),
    .byte_value_o    (byte_value_o),
    .carrier_found_o (carrier_found_o),
    .sync_match_o    (sync_match_o)
  );

  // The front end never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && q_stat.full))
    else $error("bit pushed into a full queue");

  // A sync match only comes with a good byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && sync_match_o |-> status == FS_GOOD)
    else $error("sync match without a good byte");

  // A bad start is always a one bit, a bad stop always a zero bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && status == FS_BAD_START |-> bit_value_o)
    else $error("bad start reported on a zero bit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && status == FS_BAD_STOP |-> !bit_value_o)
    else $error("bad stop reported on a one bit");

  // A good byte completes on the stop bit, which is a one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && status == FS_GOOD |-> bit_value_o)
    else $error("good byte reported on a zero bit");

endmodule

`default_nettype wire

// File: tb/sv/fsk_decode_checker.sv
`timescale 1ns / 1ps

module fsk_decode_checker
  import ftbd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       sample_valid_i,
  input  logic       sample_stall_i,
  input  logic [7:0] sample_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       bit_value_i,
  input  logic [1:0] frame_status_i,
  input  logic [7:0] byte_value_i,
  input  logic       carrier_found_i,
  input  logic       sync_match_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       wrap_up_i,
  output int         mismatch_count_o,
  output int         pending_o
);

  // Where the crossing detector stands within the current bit.
  typedef enum logic [2:0] {
    XS_SEEK,
    XS_COUNT,
    XS_ZERO_RISE,
    XS_ONE_FALL,
    XS_ONE_RISE
  } crossing_e;

  // One decoded bit as the block reports it.
  typedef struct packed {
    logic          bit_value;
    frame_status_e status;
    logic [7:0]    byte_value;
    logic          carrier;
    logic          sync;
  } decoded_bit_t;

  decoded_bit_t expected_bits[$];
  logic         wrapped;

  // Register copies.
  logic [7:0] long_thr;
  logic [7:0] sync_cfg;
  logic [4:0] carrier_cfg;

  // Decoder state.
  logic [7:0] prev_smp;
  logic       prev_ok;
  crossing_e  xing;
  logic [7:0] half_cnt;
  logic [3:0] frame_pos;
  logic [7:0] shift_byte;
  logic [4:0] ones_cnt;

  function automatic string show(decoded_bit_t r);
    return $sformatf("bit %0b status %0d byte %02h carrier %0b sync %0b",
                     r.bit_value, r.status, r.byte_value, r.carrier, r.sync);
  endfunction

  task clear_decoder();
    long_thr    = LONG_HALF_RST;
    sync_cfg    = SYNC_VALUE_RST;
    carrier_cfg = CARRIER_RUN_RST;
    prev_smp    = SAMPLE_MID;
    prev_ok     = 1'b0;
    xing        = XS_SEEK;
    half_cnt    = '0;
    frame_pos   = FR_IDLE;
    shift_byte  = '0;
    ones_cnt    = '0;
  endtask

  // Feeds one completed bit to the framer and the carrier run counter.
  task frame_bit(input logic b, output decoded_bit_t r);
    r           = '0;
    r.bit_value = b;
    r.status    = FS_NONE;
    if (frame_pos == FR_IDLE) begin
      if (!b) begin
        frame_pos  = 4'd1;
        shift_byte = '0;
      end else begin
        r.status = FS_BAD_START;
      end
    end else if (frame_pos < FR_STOP) begin
      if (b) shift_byte[3'(frame_pos - 4'd1)] = 1'b1;
      frame_pos = frame_pos + 4'd1;
    end else begin
      if (b) begin
        r.status     = FS_GOOD;
        r.byte_value = shift_byte;
        r.sync       = (shift_byte == sync_cfg);
      end else begin
        r.status = FS_BAD_STOP;
      end
      frame_pos = FR_IDLE;
    end

    // The run is clamped when the register was lowered below it.
    if (b) begin
      if (ones_cnt >= carrier_cfg) ones_cnt = carrier_cfg;
      else ones_cnt = ones_cnt + 5'd1;
    end else begin
      ones_cnt = '0;
    end
    r.carrier = (ones_cnt >= carrier_cfg);
  endtask

  // Advances the crossing detector by one sample; a bit may complete.
  task decode_sample(input logic [7:0] s, output logic hit, output decoded_bit_t r);
    logic rise;
    logic fall;
    rise     = prev_ok && (prev_smp <= RISE_LEVEL) && (s > RISE_LEVEL);
    fall     = prev_ok && (prev_smp >= FALL_LEVEL) && (s < FALL_LEVEL);
    prev_smp = s;
    prev_ok  = 1'b1;
    hit      = 1'b0;
    r        = '0;
    case (xing)
      XS_COUNT: begin
        if (half_cnt != 8'hFF) half_cnt = half_cnt + 8'd1;
        if (fall) xing = (half_cnt > long_thr) ? XS_ZERO_RISE : XS_ONE_FALL;
      end
      XS_ZERO_RISE: begin
        if (rise) begin
          frame_bit(1'b0, r);
          hit      = 1'b1;
          xing     = XS_COUNT;
          half_cnt = '0;
        end
      end
      XS_ONE_FALL: begin
        if (fall) xing = XS_ONE_RISE;
      end
      XS_ONE_RISE: begin
        if (rise) begin
          frame_bit(1'b1, r);
          hit      = 1'b1;
          xing     = XS_COUNT;
          half_cnt = '0;
        end
      end
      default: begin
        xing = XS_SEEK;
        if (rise) begin
          xing     = XS_COUNT;
          half_cnt = '0;
        end
      end
    endcase
  endtask

  // Every transaction on the three channels is handled at the edge that accepts it.
  always @(posedge clk_i or negedge rst_ni) begin
    decoded_bit_t seen;
    decoded_bit_t want;
    decoded_bit_t made;
    logic         made_valid;
    if (!rst_ni) begin
      clear_decoder();
      expected_bits.delete();
      wrapped          = 1'b0;
      mismatch_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_LONG_HALF:   long_thr = cfg_data_i;
          REG_SYNC_VALUE:  sync_cfg = cfg_data_i;
          REG_CARRIER_RUN: carrier_cfg = cfg_data_i[4:0];
          default: ;
        endcase
      end

      // A result can only stem from a sample taken at an earlier edge.
      if (out_valid_i && !out_stall_i) begin
        seen.bit_value  = bit_value_i;
        seen.status     = frame_status_e'(frame_status_i);
        seen.byte_value = byte_value_i;
        seen.carrier    = carrier_found_i;
        seen.sync       = sync_match_i;
        if (expected_bits.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("%0t: result with nothing expected: %s", $time, show(seen));
        end else begin
          want = expected_bits.pop_front();
          if (seen !== want) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10) begin
              $display("%0t: result mismatch", $time);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(seen));
            end
          end
        end
      end

      if (sample_valid_i && !sample_stall_i) begin
        decode_sample(sample_i, made_valid, made);
        if (made_valid) expected_bits.push_back(made);
      end

      // Whatever is still waiting at the end of the run never arrived.
      if (wrap_up_i && !wrapped) begin
        wrapped = 1'b1;
        if (expected_bits.size() != 0) begin
          mismatch_count_o += expected_bits.size();
          $display("%0d expected results never arrived", expected_bits.size());
        end
      end
    end
    pending_o = expected_bits.size();
  end

endmodule

// File: tb/sv/fsk_tape_bit_byte_decoder_unit_tb.sv
`timescale 1ns / 1ps

module fsk_tape_bit_byte_decoder_unit_tb;
  import ftbd_pkg::*;

  localparam int LimitCycles  = 400000;
  localparam int PressureHold = 80;
  localparam int SettleCycles = 6;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       sample_valid_i;
  logic       sample_stall_o;
  logic [7:0] sample_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       bit_value_o;
  logic [1:0] frame_status_o;
  logic [7:0] byte_value_o;
  logic       carrier_found_o;
  logic       sync_match_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;
  logic       wrap_up;
  int         mismatches;
  int         pending;

  logic [7:0] wave_q[$];
  logic       tx_calm;
  logic       rx_calm;
  logic       hold_req;
  int         cycle_cnt     = 0;
  int         samples_sent  = 0;
  int         bits_seen     = 0;
  int         good_bytes    = 0;
  int         sync_hits     = 0;
  int         settings_used = 0;

  fsk_tape_bit_byte_decoder_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_valid_i),
    .sample_stall_o (sample_stall_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .bit_value_o    (bit_value_o),
    .frame_status_o (frame_status_o),
    .byte_value_o   (byte_value_o),
    .carrier_found_o(carrier_found_o),
    .sync_match_o   (sync_match_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  fsk_decode_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .sample_valid_i  (sample_valid_i),
    .sample_stall_i  (sample_stall_o),
    .sample_i        (sample_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .bit_value_i     (bit_value_o),
    .frame_status_i  (frame_status_o),
    .byte_value_i    (byte_value_o),
    .carrier_found_i (carrier_found_o),
    .sync_match_i    (sync_match_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .wrap_up_i       (wrap_up),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LimitCycles) begin
      $display("FAIL");
      $finish;
    end
  end

  // Tally of result transactions for the closing summary.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      bits_seen <= bits_seen + 1;
      if (frame_status_o == FS_GOOD) good_bytes <= good_bytes + 1;
      if (sync_match_o) sync_hits <= sync_hits + 1;
    end
  end

  // Result side: short random stalls, or one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (PressureHold) @(negedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!rx_calm && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offers one sample and returns at the falling edge after it was taken.
  task automatic push_sample(input logic [7:0] value);
    if (!tx_calm && $urandom_range(0, 9) == 0) begin
      sample_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    sample_valid_i <= 1'b1;
    sample_i       <= value;
    @(posedge clk_i);
    while (sample_stall_o) @(posedge clk_i);
    samples_sent++;
    @(negedge clk_i);
  endtask

  task automatic play_wave();
    while (wave_q.size() != 0) push_sample(wave_q.pop_front());
    sample_valid_i <= 1'b0;
  endtask

  // One tone cycle: a rise, a high run, a fall and a short low run.
  task automatic add_cycle(input int high_len);
    int low_len;
    low_len = $urandom_range(0, 2);
    wave_q.push_back(8'($urandom_range(139, 255)));
    repeat (high_len) wave_q.push_back(8'($urandom_range(118, 255)));
    wave_q.push_back(8'($urandom_range(0, 117)));
    repeat (low_len) wave_q.push_back(8'($urandom_range(0, 117)));
  endtask

  // High run that still counts as a short half-cycle, often right at the boundary.
  function automatic int short_len(input int thr);
    int top_len;
    top_len = (thr > 8) ? 8 : thr - 1;
    if (thr <= 16 && $urandom_range(0, 3) == 0) return thr - 1;
    return $urandom_range(0, top_len);
  endfunction

  // A zero is one long cycle, a one is two short cycles.
  task automatic add_bit(input logic b, input int thr);
    if (!b) add_cycle(thr + $urandom_range(0, 2));
    else repeat (2) add_cycle(short_len(thr));
  endtask

  task automatic add_frame(input logic [7:0] value, input logic stop_ok, input int thr);
    add_bit(1'b0, thr);
    for (int i = 0; i < 8; i++) add_bit(value[i], thr);
    add_bit(stop_ok, thr);
  endtask

  // Leader tone, then frames; a messy run mixes in noise and broken bit runs.
  task automatic run_frames(input int thr, input logic [7:0] sync_val, input int frames,
                            input int leader, input logic messy);
    int pick;
    repeat (leader) add_bit(1'b1, thr);
    repeat (frames) begin
      pick = $urandom_range(0, 9);
      if (messy && pick == 0) begin
        repeat ($urandom_range(4, 16)) wave_q.push_back(8'($urandom_range(0, 255)));
      end else if (messy && pick == 1) begin
        repeat ($urandom_range(1, 12)) add_bit(1'($urandom_range(0, 1)), thr);
      end else begin
        add_frame(($urandom_range(0, 2) == 0) ? sync_val : 8'($urandom_range(0, 255)),
                  ($urandom_range(0, 7) != 0), thr);
      end
    end
    play_wave();
  endtask

  // Waits until the block is idle, then writes all three registers.
  task automatic set_registers(input logic [7:0] thr, input logic [7:0] sync_val,
                               input logic [7:0] carrier);
    logic [1:0] reg_idx[3];
    logic [7:0] reg_val[3];
    reg_idx = '{REG_LONG_HALF, REG_SYNC_VALUE, REG_CARRIER_RUN};
    reg_val = '{thr, sync_val, carrier};
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    for (int r = 0; r < 3; r++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= reg_idx[r];
      cfg_data_i  <= reg_val[r];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [7:0] sync_val;
    rst_ni         = 1'b0;
    sample_valid_i = 1'b0;
    sample_i       = '0;
    out_stall_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = REG_LONG_HALF;
    cfg_data_i     = '0;
    wrap_up        = 1'b0;
    tx_calm        = 1'b0;
    rx_calm        = 1'b0;
    hold_req       = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed start on reset settings: a first sample that would be a rise,
    // both crossing levels, a short one that is a bad start bit, then a long
    // zero that opens a frame.
    wave_q = '{8'd255, 8'd0, 8'd138, 8'd139, 8'd255, 8'd118, 8'd117, 8'd139, 8'd117,
               8'd140};
    repeat (12) wave_q.push_back(8'd200);
    wave_q.push_back(8'd0);
    wave_q.push_back(8'd139);
    play_wave();

    // Threshold and carrier run of one, sync on zero, one bad stop bit.
    set_registers(8'd1, 8'd0, 8'd1);
    repeat (3) add_bit(1'b1, 1);
    add_frame(8'h00, 1'b1, 1);
    add_frame(8'hFF, 1'b0, 1);
    play_wave();

    // Highest carrier run and sync value while the receiver holds off and samples
    // keep coming, so the block backs up; the long run of ones stays clamped.
    set_registers(8'd1, 8'hFF, 8'd31);
    tx_calm  = 1'b1;
    hold_req = 1'b1;
    repeat (33) add_bit(1'b1, 1);
    add_frame(8'hFF, 1'b1, 1);
    play_wave();
    tx_calm = 1'b0;

    // Threshold one below full scale with a lowered carrier run: the run is clamped and one
    // half-cycle saturates the counter.
    sync_val = 8'($urandom_range(0, 255));
    set_registers(8'd254, sync_val, 8'd2);
    repeat (2) add_cycle($urandom_range(0, 5));
    add_cycle(256);
    repeat (2) add_cycle($urandom_range(0, 5));
    play_wave();

    // Threshold at full scale makes every half-cycle short; carrier run of zero.
    set_registers(8'd255, sync_val, 8'd0);
    add_cycle(40);
    add_cycle(2);
    repeat (3) add_bit(1'b1, 255);
    play_wave();

    // Random settings and noisy traffic to round out the run.
    while (samples_sent < 800 || bits_seen < 48) begin
      sync_val = 8'($urandom_range(0, 255));
      set_registers(8'($urandom_range(1, 12)), sync_val, 8'($urandom_range(1, 31)));
      run_frames(int'(u_checker.long_thr), sync_val, $urandom_range(1, 2),
                 $urandom_range(0, 4), 1'b1);
    end

    // Quiet tail with no idling on either side; a last rise closes the final bit.
    tx_calm  = 1'b1;
    rx_calm  = 1'b1;
    sync_val = 8'($urandom_range(0, 255));
    set_registers(8'd3, sync_val, 8'd8);
    repeat (4) add_bit(1'b1, 3);
    add_frame(($urandom_range(0, 1) == 0) ? sync_val : 8'($urandom_range(0, 255)),
              1'b1, 3);
    wave_q.push_back(8'd200);
    play_wave();

    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    wrap_up <= 1'b1;
    @(negedge clk_i);

    $display("Decoded %0d bits from %0d samples: %0d good bytes, %0d sync matches.",
             bits_seen, samples_sent, good_bytes, sync_hits);
    $display("Register settings exercised: %0d, extremes included.", settings_used);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
